@@ hdl/hsl2rgb_pkg.sv @@
// Shared types and constants for the HSL to RGB conversion pipeline.
// Used by every module under hdl/; depends on nothing else.
`default_nettype none

package hsl2rgb_pkg;

  // Input ranges
  localparam int HUE_TURN = 360;  // one full turn in degrees
  localparam int PCT_MAX  = 99;   // clamp for saturation and lightness
  localparam int PCT_FULL = 100;
  localparam int SEXT_DEG = 60;   // degrees per hue sextant

  // Chroma: floor(a * 256 / 10000) = (a * CHROMA_RECIP) >> CHROMA_SHIFT, a <= 9900
  localparam int CHROMA_RECIP = 214749;
  localparam int CHROMA_SHIFT = 23;

  // Position in sextant: floor(r * 256 / 60) = (r * POS_RECIP) >> POS_SHIFT, r <= 59
  localparam int POS_RECIP = 4370;
  localparam int POS_SHIFT = 10;

  // Scaled lightness: floor(l * 512 / 100) = (l * LM_RECIP) >> LM_SHIFT, l <= 99
  localparam int LM_RECIP = 41944;
  localparam int LM_SHIFT = 13;

  // Hue sextants, red through magenta back to red
  typedef enum logic [2:0] {
    SEXT_R_TO_Y = 3'd0,
    SEXT_Y_TO_G = 3'd1,
    SEXT_G_TO_C = 3'd2,
    SEXT_C_TO_B = 3'd3,
    SEXT_B_TO_M = 3'd4,
    SEXT_M_TO_R = 3'd5
  } sextant_t;

  // Front end to chroma stages
  typedef struct packed {
    sextant_t   sext;
    logic [5:0] rem;         // degrees into the sextant, 0..59
    logic [13:0] span_sat;   // (100 - |2l - 100|) * s
    logic [8:0] lit_scaled;  // floor(l * 512 / 100)
  } front_t;

  // Chroma stages to channel mix
  typedef struct packed {
    sextant_t          sext;
    logic [7:0]        chroma;
    logic [7:0]        second;  // second component x
    logic signed [9:0] diff;    // lit_scaled - chroma
  } chroma_t;

endpackage

`default_nettype wire

@@ hdl/hsl_to_rgb_fixed_point_top.sv @@
// HSL to RGB conversion, top level: front end, chroma stages and channel mix.
// Depends on hsl2rgb_pkg, hsl2rgb_front, hsl2rgb_chroma and hsl2rgb_mix.
//
// Usage:
//   Input channel hsl_valid/hsl_ready carries hue (degrees, any 10-bit value,
//   taken modulo 360), saturation and lightness (percent, clamped to 99).
//   Output channel rgb_valid/rgb_ready returns red, green and blue, 8 bits each.
//   A request is taken on a clock edge where valid and ready are both high.
//   Pipeline: five register stages (hue/clamp, sextant/products, chroma,
//   second component, channel mix). The first loads at the accepting edge,
//   and rgb_valid rises once the request reaches the channel mix stage.
//   Throughput: one conversion per clock while rgb_ready is high; every stage
//   holds one request and moves on as soon as the stage after it is free.
//   Stall: when rgb_ready is low the output holds its result; earlier stages
//   keep filling their empty slots, and hsl_ready drops only once all five
//   stages hold a request. Nothing is dropped or repeated.
//   Reset (rst, synchronous, active high) empties the pipeline; the block
//   keeps no other state and accepts requests on the next cycle.
`default_nettype none

module hsl_to_rgb_fixed_point_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       hsl_valid,
  output logic            hsl_ready,
  input  wire logic [9:0] hue,
  input  wire logic [6:0] saturation,
  input  wire logic [6:0] lightness,
  output logic            rgb_valid,
  input  wire logic       rgb_ready,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue
);

  logic                 front_valid;
  logic                 front_ready;
  hsl2rgb_pkg::front_t  front_data;
  logic                 chroma_valid;
  logic                 chroma_ready;
  hsl2rgb_pkg::chroma_t chroma_data;

  // Hue reduction, clamps, sextant and first products
  hsl2rgb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (hsl_valid),
    .in_ready   (hsl_ready),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .out_valid  (front_valid),
    .out_ready  (front_ready),
    .out_data   (front_data)
  );

  // Chroma and second component
  hsl2rgb_chroma u_chroma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (chroma_valid),
    .out_ready (chroma_ready),
    .out_data  (chroma_data)
  );

  // Offset, placement and output register
  hsl2rgb_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chroma_valid),
    .in_ready  (chroma_ready),
    .in_data   (chroma_data),
    .out_valid (rgb_valid),
    .out_ready (rgb_ready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule

`default_nettype wire

@@ hdl/hsl2rgb_front.sv @@
// Front end: hue reduction, percent clamps, sextant split and the first products.
// Two register stages with valid/ready; depends on hsl2rgb_pkg.
`default_nettype none

module hsl2rgb_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [9:0]          hue,
  input  wire logic [6:0]          saturation,
  input  wire logic [6:0]          lightness,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hsl2rgb_pkg::front_t      out_data
);

  // Stage A registers
  logic       a_valid;
  logic [8:0] a_hue;
  logic [6:0] a_sat;
  logic [6:0] a_lit;
  logic [6:0] a_span;

  // Stage B registers
  logic                 b_valid;
  hsl2rgb_pkg::front_t  b_data;

  logic a_ready;
  logic b_ready;

  // Stage A combinational
  logic [9:0] hue_once;
  logic [9:0] hue_twice;
  logic [6:0] sat_clamp;
  logic [6:0] lit_clamp;
  logic [7:0] lit_dbl;
  logic [7:0] lit_dev;
  logic [7:0] span_wide;

  // Stage B combinational
  hsl2rgb_pkg::sextant_t sext;
  logic [8:0]            sext_base;
  logic [8:0]            rem_wide;
  logic [13:0]           span_sat;
  logic [21:0]           lit_prod;

  // Stall chain: a stage loads when empty or when its contents move on
  assign b_ready  = !b_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // Hue modulo 360 for any 10-bit value, percent clamps, span of chroma
  always_comb begin
    hue_once  = (hue >= 10'(hsl2rgb_pkg::HUE_TURN)) ?
                hue - 10'(hsl2rgb_pkg::HUE_TURN) : hue;
    hue_twice = (hue_once >= 10'(hsl2rgb_pkg::HUE_TURN)) ?
                hue_once - 10'(hsl2rgb_pkg::HUE_TURN) : hue_once;
    sat_clamp = (saturation > 7'(hsl2rgb_pkg::PCT_MAX)) ?
                7'(hsl2rgb_pkg::PCT_MAX) : saturation;
    lit_clamp = (lightness > 7'(hsl2rgb_pkg::PCT_MAX)) ?
                7'(hsl2rgb_pkg::PCT_MAX) : lightness;
    lit_dbl   = {lit_clamp, 1'b0};
    lit_dev   = (lit_dbl >= 8'(hsl2rgb_pkg::PCT_FULL)) ?
                lit_dbl - 8'(hsl2rgb_pkg::PCT_FULL) :
                8'(hsl2rgb_pkg::PCT_FULL) - lit_dbl;
    span_wide = 8'(hsl2rgb_pkg::PCT_FULL) - lit_dev;
  end

  // Sextant by compare chain, saturation product, scaled lightness
  always_comb begin
    if (a_hue >= 9'(hsl2rgb_pkg::SEXT_DEG * 5)) begin
      sext      = hsl2rgb_pkg::SEXT_M_TO_R;
      sext_base = 9'(hsl2rgb_pkg::SEXT_DEG * 5);
    end else if (a_hue >= 9'(hsl2rgb_pkg::SEXT_DEG * 4)) begin
      sext      = hsl2rgb_pkg::SEXT_B_TO_M;
      sext_base = 9'(hsl2rgb_pkg::SEXT_DEG * 4);
    end else if (a_hue >= 9'(hsl2rgb_pkg::SEXT_DEG * 3)) begin
      sext      = hsl2rgb_pkg::SEXT_C_TO_B;
      sext_base = 9'(hsl2rgb_pkg::SEXT_DEG * 3);
    end else if (a_hue >= 9'(hsl2rgb_pkg::SEXT_DEG * 2)) begin
      sext      = hsl2rgb_pkg::SEXT_G_TO_C;
      sext_base = 9'(hsl2rgb_pkg::SEXT_DEG * 2);
    end else if (a_hue >= 9'(hsl2rgb_pkg::SEXT_DEG)) begin
      sext      = hsl2rgb_pkg::SEXT_Y_TO_G;
      sext_base = 9'(hsl2rgb_pkg::SEXT_DEG);
    end else begin
      sext      = hsl2rgb_pkg::SEXT_R_TO_Y;
      sext_base = 9'd0;
    end
    rem_wide = a_hue - sext_base;
    span_sat = 14'(a_span) * 14'(a_sat);
    lit_prod = 22'(a_lit) * 22'(hsl2rgb_pkg::LM_RECIP);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= in_valid;
      if (b_ready) b_valid <= a_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_hue  <= hue_twice[8:0];
      a_sat  <= sat_clamp;
      a_lit  <= lit_clamp;
      a_span <= span_wide[6:0];
    end
    if (b_ready && a_valid) begin
      b_data.sext       <= sext;
      b_data.rem        <= rem_wide[5:0];
      b_data.span_sat   <= span_sat;
      b_data.lit_scaled <= lit_prod[hsl2rgb_pkg::LM_SHIFT +: 9];
    end
  end

  assign out_valid = b_valid;
  assign out_data  = b_data;

endmodule

`default_nettype wire

@@ hdl/hsl2rgb_chroma.sv @@
// Chroma, position in sextant, second component and lightness difference.
// Two register stages with valid/ready; depends on hsl2rgb_pkg.
`default_nettype none

module hsl2rgb_chroma (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire hsl2rgb_pkg::front_t in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hsl2rgb_pkg::chroma_t     out_data
);

  // Stage C registers
  logic                  c_valid;
  hsl2rgb_pkg::sextant_t c_sext;
  logic [7:0]            c_chroma;
  logic [7:0]            c_pos;
  logic [8:0]            c_lit;

  // Stage D registers
  logic                 d_valid;
  hsl2rgb_pkg::chroma_t d_data;

  logic c_ready;
  logic d_ready;

  logic [31:0] chroma_prod;
  logic [17:0] pos_prod;
  logic [8:0]  weight;
  logic [16:0] second_prod;
  logic [9:0]  diff;

  assign d_ready  = !d_valid || out_ready;
  assign c_ready  = !c_valid || d_ready;
  assign in_ready = c_ready;

  // Reciprocal multiplies stand in for the divisions by 10000 and 60
  always_comb begin
    chroma_prod = 32'(in_data.span_sat) * 32'(hsl2rgb_pkg::CHROMA_RECIP);
    pos_prod    = 18'(in_data.rem) * 18'(hsl2rgb_pkg::POS_RECIP);
  end

  // Odd sextants fall from chroma, even ones rise toward it
  always_comb begin
    weight      = c_sext[0] ? 9'd256 - {1'b0, c_pos} : {1'b0, c_pos};
    second_prod = 17'(c_chroma) * 17'(weight);
    diff        = {1'b0, c_lit} - {2'b00, c_chroma};
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (c_ready) c_valid <= in_valid;
      if (d_ready) d_valid <= c_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (c_ready && in_valid) begin
      c_sext   <= in_data.sext;
      c_chroma <= chroma_prod[hsl2rgb_pkg::CHROMA_SHIFT +: 8];
      c_pos    <= pos_prod[hsl2rgb_pkg::POS_SHIFT +: 8];
      c_lit    <= in_data.lit_scaled;
    end
    if (d_ready && c_valid) begin
      d_data.sext   <= c_sext;
      d_data.chroma <= c_chroma;
      d_data.second <= second_prod[15:8];
      d_data.diff   <= $signed(diff);
    end
  end

  assign out_valid = d_valid;
  assign out_data  = d_data;

endmodule

`default_nettype wire

@@ hdl/hsl2rgb_mix.sv @@
// Channel mix: lightness offset, sextant placement, saturation to 8 bits.
// One output register stage with valid/ready; depends on hsl2rgb_pkg.
`default_nettype none

module hsl2rgb_mix (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire hsl2rgb_pkg::chroma_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                red,
  output logic [7:0]                green,
  output logic [7:0]                blue
);

  logic       valid;
  logic [7:0] red_q;
  logic [7:0] green_q;
  logic [7:0] blue_q;

  logic signed [9:0]  diff_adj;
  logic signed [8:0]  offset;
  logic [7:0]         r0;
  logic [7:0]         g0;
  logic [7:0]         b0;
  logic signed [10:0] sum_r;
  logic signed [10:0] sum_g;
  logic signed [10:0] sum_b;

  // Clip a signed sum to 0..255
  function automatic logic [7:0] sat8(input logic signed [10:0] v);
    logic [7:0] res;
    if (v[10]) begin
      res = 8'd0;
    end else if (v[9:8] != 2'b00) begin
      res = 8'hff;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  assign in_ready = !valid || out_ready;

  // Offset m = diff / 2, rounded toward zero
  always_comb begin
    diff_adj = in_data.diff + $signed({9'd0, in_data.diff[9]});
    offset   = diff_adj[9:1];
  end

  // Place chroma and the second component by sextant
  always_comb begin
    case (in_data.sext)
      hsl2rgb_pkg::SEXT_R_TO_Y: begin
        r0 = in_data.chroma; g0 = in_data.second; b0 = 8'd0;
      end
      hsl2rgb_pkg::SEXT_Y_TO_G: begin
        r0 = in_data.second; g0 = in_data.chroma; b0 = 8'd0;
      end
      hsl2rgb_pkg::SEXT_G_TO_C: begin
        r0 = 8'd0; g0 = in_data.chroma; b0 = in_data.second;
      end
      hsl2rgb_pkg::SEXT_C_TO_B: begin
        r0 = 8'd0; g0 = in_data.second; b0 = in_data.chroma;
      end
      hsl2rgb_pkg::SEXT_B_TO_M: begin
        r0 = in_data.second; g0 = 8'd0; b0 = in_data.chroma;
      end
      default: begin
        r0 = in_data.chroma; g0 = 8'd0; b0 = in_data.second;
      end
    endcase
    sum_r = $signed({3'b000, r0}) + $signed({{2{offset[8]}}, offset});
    sum_g = $signed({3'b000, g0}) + $signed({{2{offset[8]}}, offset});
    sum_b = $signed({3'b000, b0}) + $signed({{2{offset[8]}}, offset});
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      red_q   <= sat8(sum_r);
      green_q <= sat8(sum_g);
      blue_q  <= sat8(sum_b);
    end
  end

  assign out_valid = valid;
  assign red       = red_q;
  assign green     = green_q;
  assign blue      = blue_q;

endmodule

`default_nettype wire

@@ sim/hsl_rgb_checker.sv @@
`timescale 1ns / 1ps
// Result checker for hsl_to_rgb_fixed_point_top: predicts red/green/blue for every
// accepted HSL request and compares each accepted RGB result in order.
// Depends on hsl2rgb_pkg for the sextant type and the range constants.

module hsl_rgb_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       hsl_valid,
  input  logic       hsl_ready,
  input  logic [9:0] hue,
  input  logic [6:0] saturation,
  input  logic [6:0] lightness,
  input  logic       rgb_valid,
  input  logic       rgb_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output int         mismatches,
  output int         in_flight
);

  // One predicted pixel, with the request that produced it for reporting
  typedef struct {
    logic [9:0] hue;
    logic [6:0] sat;
    logic [6:0] lit;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  pixel_t rgb_due[$];

  // Saturate a channel sum to 0..255
  function automatic logic [7:0] clamp_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Fixed-point HSL to RGB with truncating divisions
  function automatic pixel_t convert_hsl(input logic [9:0] hue_in, input logic [6:0] sat_in,
                                         input logic [6:0] lit_in);
    int h, s, l, span, c, pos, t, x, m;
    int r0, g0, b0;
    hsl2rgb_pkg::sextant_t sext;
    pixel_t px;
    h = hue_in;
    // up to two turns off the 10-bit hue
    if (h >= hsl2rgb_pkg::HUE_TURN) h -= hsl2rgb_pkg::HUE_TURN;
    if (h >= hsl2rgb_pkg::HUE_TURN) h -= hsl2rgb_pkg::HUE_TURN;
    s = (sat_in > hsl2rgb_pkg::PCT_MAX) ? hsl2rgb_pkg::PCT_MAX : sat_in;
    l = (lit_in > hsl2rgb_pkg::PCT_MAX) ? hsl2rgb_pkg::PCT_MAX : lit_in;

    span = 2 * l - hsl2rgb_pkg::PCT_FULL;
    if (span < 0) span = -span;
    c = ((hsl2rgb_pkg::PCT_FULL - span) * s * 256) / 10000;

    sext = hsl2rgb_pkg::sextant_t'(h / hsl2rgb_pkg::SEXT_DEG);
    pos = ((h - hsl2rgb_pkg::SEXT_DEG * (h / hsl2rgb_pkg::SEXT_DEG)) * 256) /
          hsl2rgb_pkg::SEXT_DEG;
    t = ((h / hsl2rgb_pkg::SEXT_DEG) % 2) * 256 + pos - 256;
    if (t < 0) t = -t;
    x = (c * (256 - t)) / 256;

    case (sext)
      hsl2rgb_pkg::SEXT_R_TO_Y: begin r0 = c; g0 = x; b0 = 0; end
      hsl2rgb_pkg::SEXT_Y_TO_G: begin r0 = x; g0 = c; b0 = 0; end
      hsl2rgb_pkg::SEXT_G_TO_C: begin r0 = 0; g0 = c; b0 = x; end
      hsl2rgb_pkg::SEXT_C_TO_B: begin r0 = 0; g0 = x; b0 = c; end
      hsl2rgb_pkg::SEXT_B_TO_M: begin r0 = x; g0 = 0; b0 = c; end
      default:                  begin r0 = c; g0 = 0; b0 = x; end
    endcase

    // lightness offset, may go negative; division truncates toward zero
    m = ((l * 512) / hsl2rgb_pkg::PCT_FULL - c) / 2;

    px.hue = hue_in;
    px.sat = sat_in;
    px.lit = lit_in;
    px.r = clamp_byte(r0 + m);
    px.g = clamp_byte(g0 + m);
    px.b = clamp_byte(b0 + m);
    return px;
  endfunction

  initial mismatches = 0;

  assign in_flight = rgb_due.size();

  // Compare the result first, then queue the new request's prediction
  always @(posedge clk) begin
    pixel_t want;
    if (!rst) begin
      if (rgb_valid && rgb_ready) begin
        if (rgb_due.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("%0t: rgb result %0d/%0d/%0d with no request pending",
                     $realtime, red, green, blue);
        end else begin
          want = rgb_due.pop_front();
          if (red !== want.r || green !== want.g || blue !== want.b) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("%0t: hsl %0d/%0d/%0d: got rgb %0d/%0d/%0d, want %0d/%0d/%0d",
                       $realtime, want.hue, want.sat, want.lit, red, green, blue,
                       want.r, want.g, want.b);
          end
        end
      end
      if (hsl_valid && hsl_ready)
        rgb_due.push_back(convert_hsl(hue, saturation, lightness));
    end
  end

endmodule

@@ sim/hsl_to_rgb_fixed_point_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for hsl_to_rgb_fixed_point_top: drives HSL requests and RGB stalls
// with random idle bursts. Depends on the RTL under hdl/ and sim/hsl_rgb_checker.sv.

module hsl_to_rgb_fixed_point_top_tb;

  localparam int RANDOM_ITEMS = 1350;
  localparam int TAIL_ITEMS   = 150;   // no idling on either side at the end
  localparam int STALL_LIMIT  = 1000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES = 12;

  logic       clk = 1'b0;
  logic       rst;
  logic       hsl_valid;
  logic       hsl_ready;
  logic [9:0] hue;
  logic [6:0] saturation;
  logic [6:0] lightness;
  logic       rgb_valid;
  logic       rgb_ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  int mismatches;
  int in_flight;
  int calm_left;
  int quiet_cycles;
  bit tail;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  hsl_to_rgb_fixed_point_top dut (
    .clk        (clk),
    .rst        (rst),
    .hsl_valid  (hsl_valid),
    .hsl_ready  (hsl_ready),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .rgb_valid  (rgb_valid),
    .rgb_ready  (rgb_ready),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  hsl_rgb_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .hsl_valid  (hsl_valid),
    .hsl_ready  (hsl_ready),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .rgb_valid  (rgb_valid),
    .rgb_ready  (rgb_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  // Present one request, hold it until taken, then maybe idle for a burst
  task automatic push_hsl(input logic [9:0] h, input logic [6:0] s, input logic [6:0] l);
    hsl_valid  <= 1'b1;
    hue        <= h;
    saturation <= s;
    lightness  <= l;
    do @(posedge clk); while (!hsl_ready);
    if (calm_left > 0) begin
      calm_left--;
    end else if (!tail && $urandom_range(0, 3) == 0) begin
      hsl_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end else if (!tail && $urandom_range(0, 40) == 0) begin
      calm_left = $urandom_range(20, 80);
    end
  endtask

  // Receiver stalls: random bursts, with long stretches of steady ready
  initial begin
    rgb_ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (!tail && $urandom_range(0, 2) == 0) begin
        rgb_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      rgb_ready <= 1'b1;
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(40, 120)) @(posedge clk);
      else
        repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Hang detection: count cycles in which neither channel moves
  always @(posedge clk) begin
    if ((hsl_valid && hsl_ready) || (rgb_valid && rgb_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus: directed corners, then random requests
  initial begin
    int dir_hue[25] = '{0, 0, 59, 60, 119, 120, 180, 240, 300, 359, 360, 719, 720, 1023,
                        30, 30, 200, 200, 90, 0, 45, 330, 150, 270, 512};
    int dir_sat[25] = '{0, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99,
                        100, 127, 99, 99, 50, 99, 127, 1, 99, 64, 77};
    int dir_lit[25] = '{0, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50,
                        50, 50, 100, 127, 99, 0, 127, 1, 49, 25, 75};
    logic [9:0] h;
    logic [6:0] s;
    logic [6:0] l;

    rst          <= 1'b1;
    hsl_valid    <= 1'b0;
    hue          <= '0;
    saturation   <= '0;
    lightness    <= '0;
    calm_left    = 0;
    tail         = 1'b0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // hue wrap points, every sextant edge, clamp edges
    foreach (dir_hue[i])
      push_hsl(dir_hue[i][9:0], dir_sat[i][6:0], dir_lit[i][6:0]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - TAIL_ITEMS) tail = 1'b1;
      // mostly in-range values, some across the full field width
      h = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                      : 10'($urandom_range(0, 719));
      s = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                      : 7'($urandom_range(0, 99));
      l = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                      : 7'($urandom_range(0, 99));
      push_hsl(h, s, l);
    end
    hsl_valid <= 1'b0;

    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && in_flight == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ hsl_to_rgb_fixed_point_top.f @@
hdl/hsl2rgb_pkg.sv
hdl/hsl2rgb_front.sv
hdl/hsl2rgb_chroma.sv
hdl/hsl2rgb_mix.sv
hdl/hsl_to_rgb_fixed_point_top.sv
sim/hsl_rgb_checker.sv
sim/hsl_to_rgb_fixed_point_top_tb.sv
